// ===== rtl/sawq_pkg.sv =====
`default_nettype none
package sawq_pkg;

  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned WAITER_ID_BITS = 8;
  localparam int unsigned CNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TICK_W         = 63;
  localparam int unsigned DL_W           = 64;

  localparam logic [1:0] STATUS_WOKEN    = 2'd0;
  localparam logic [1:0] STATUS_NONE_DUE = 2'd1;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SLEEP = 1'b1;

  typedef struct packed {
    logic signed [DL_W-1:0]     deadline;
    logic [WAITER_ID_BITS-1:0]  waiter;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sawq_cell.sv =====
`default_nettype none
module sawq_cell (
  input  wire logic            clk_i,
  input  wire sawq_pkg::ctrl_t ctrl_i,
  input  wire sawq_pkg::entry_t new_i,
  input  wire logic            valid_i,
  input  wire sawq_pkg::entry_t prev_i,
  input  wire logic            prev_gt_i,
  input  wire sawq_pkg::entry_t next_i,
  output logic                 gt_o,
  output sawq_pkg::entry_t     entry_o
);

  sawq_pkg::entry_t entry_q, entry_d;

  // An empty cell counts as later than any new alarm.
  assign gt_o = !valid_i || (entry_q.deadline > new_i.deadline);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = next_i;
    end else if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        entry_d = prev_i;
      end else if (gt_o) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== rtl/sorted_alarm_wakeup_queue.sv =====
// Sleep request: one result, registered at the accepting edge.
// Tick: one result per cycle unless the output stalls, one for each alarm popped from the
// front of the cell chain (up to QUEUE_DEPTH), or a single status result.
// The next item is taken once the last result of the previous one is registered and the
// output register is empty or transfers in that cycle; a stalled output holds the input.
// Asynchronous reset (rst_ni low) clears the tick counter, alarm count and output valid.
`default_nettype none
module sorted_alarm_wakeup_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [31:0] sleep_ticks, [39:32] waiter_id
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [7:0] woken_id, [70:8] now_ticks, [71] zero
  output logic [1:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast
);

  localparam int unsigned QD  = sawq_pkg::QUEUE_DEPTH;
  localparam int unsigned IDW = sawq_pkg::WAITER_ID_BITS;
  localparam int unsigned CW  = sawq_pkg::CNT_W;
  localparam int unsigned TW  = sawq_pkg::TICK_W;
  localparam int unsigned DW  = sawq_pkg::DL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] tick_q, tick_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [7:0]    out_id_q, out_id_d;
  logic [TW-1:0] out_now_q, out_now_d;
  logic          out_last_q, out_last_d;

  sawq_pkg::ctrl_t  ctrl;
  sawq_pkg::entry_t new_entry;
  sawq_pkg::entry_t ent [QD];
  logic             gt [QD];

  logic                 accept, out_free, full, front_due, second_due;
  logic signed [DW-1:0] sleep_ext, dl_sum, now_signed;
  logic [15:0]          id_in_wide, id_out_wide;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CW'(QD));

  assign sleep_ext = DW'($signed(s_axis_tdata[31:0]));
  assign dl_sum    = $signed({1'b0, tick_q}) + sleep_ext;
  assign id_in_wide = 16'(s_axis_tdata[39:32]);

  always_comb begin
    new_entry.waiter = id_in_wide[IDW-1:0];
    // Saturate a positive overflow at the largest signed deadline.
    if (!s_axis_tdata[31] && dl_sum[DW-1]) begin
      new_entry.deadline = {1'b0, {(DW-1){1'b1}}};
    end else begin
      new_entry.deadline = dl_sum;
    end
  end

  assign now_signed  = $signed({1'b0, tick_q});
  assign front_due   = (cnt_q != '0) && (ent[0].deadline <= now_signed);
  assign second_due  = (cnt_q > CW'(1)) && (ent[1].deadline <= now_signed);
  assign id_out_wide = 16'(ent[0].waiter);

  always_comb begin
    ctrl.ins = accept && (s_axis_tuser == sawq_pkg::CMD_SLEEP) && !full;
    ctrl.pop = (state_q == ST_POP) && out_free && front_due;
  end

  for (genvar i = 0; i < QD; i++) begin : g_cell
    sawq_pkg::entry_t prev_e, next_e;
    logic             prev_gt;
    if (i == 0) begin : g_first
      assign prev_e  = new_entry;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_e  = ent[i-1];
      assign prev_gt = gt[i-1];
    end
    if (i == QD - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_notlast
      assign next_e = ent[i+1];
    end
    sawq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .valid_i   (cnt_q > CW'(i)),
      .prev_i    (prev_e),
      .prev_gt_i (prev_gt),
      .next_i    (next_e),
      .gt_o      (gt[i]),
      .entry_o   (ent[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    tick_d       = tick_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_now_d    = out_now_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == sawq_pkg::CMD_SLEEP) begin
            out_valid_d  = 1'b1;
            out_status_d = full ? sawq_pkg::STATUS_FULL : sawq_pkg::STATUS_ACCEPTED;
            out_id_d     = s_axis_tdata[39:32] & 8'(id_in_wide[IDW-1:0]);
            out_now_d    = tick_q;
            out_last_d   = 1'b1;
            if (!full) begin
              cnt_d = cnt_q + CW'(1);
            end
          end else begin
            if (tick_q != '1) begin
              tick_d = tick_q + TW'(1);
            end
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_now_d   = tick_q;
          if (front_due) begin
            out_status_d = sawq_pkg::STATUS_WOKEN;
            out_id_d     = id_out_wide[7:0];
            out_last_d   = !second_due;
            cnt_d        = cnt_q - CW'(1);
            if (!second_due) begin
              state_d = ST_IDLE;
            end
          end else begin
            // Only reached on a tick that wakes nothing.
            out_status_d = sawq_pkg::STATUS_NONE_DUE;
            out_id_d     = '0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_now_q    <= out_now_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_now_q, out_id_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_sorted_alarm_wakeup_queue.sv =====
`default_nettype none
module tb_sorted_alarm_wakeup_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import sawq_pkg::*;

  localparam int MAX_WAKE_PER_TICK = 16;
  localparam int HOLD_LEN          = 300;
  localparam int ITEMS_PER_PHASE   = 57;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_e;

  typedef struct {
    logic        cmd;
    logic [31:0] sleep_ticks;
    logic [7:0]  waiter_id;
  } timer_cmd_t;

  typedef struct {
    logic [1:0]        status;
    logic [7:0]        waiter;
    logic [TICK_W-1:0] now;
    logic              last;
  } wake_rsp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // [31:0] sleep_ticks, [39:32] waiter_id
  logic        s_axis_tuser  = 1'b0; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // [7:0] woken_id, [70:8] now_ticks, [71] zero
  logic [1:0]  m_axis_tuser;         // status
  logic        m_axis_tlast;

  sorted_alarm_wakeup_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  phase_e     phase = PH_FREE;
  timer_cmd_t cmd_q[$];
  wake_rsp_t  wake_exp_q[$];
  timer_cmd_t drv_item;
  wake_rsp_t  got_want;
  logic       in_taken    = 1'b0;
  logic       send_gap;
  logic       recv_ok;
  int         hold_cycles = 0;
  int         err_cnt     = 0;

  // Alarm store mirror, sorted by signed deadline, earliest first
  logic [TICK_W-1:0]         model_ticks = '0;
  logic signed [DL_W-1:0]    model_dl [QUEUE_DEPTH];
  logic [WAITER_ID_BITS-1:0] model_wt [QUEUE_DEPTH];
  int                        model_cnt   = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic advance_timer_model(input timer_cmd_t it);
    logic signed [DL_W-1:0] span;
    logic signed [DL_W-1:0] due;
    logic signed [DL_W-1:0] now64;
    int                     pos;
    int                     i;
    int                     n;
    wake_rsp_t              r;
    now64 = {1'b0, model_ticks};
    if (it.cmd == CMD_SLEEP) begin
      r.waiter = it.waiter_id[WAITER_ID_BITS-1:0];
      r.now    = model_ticks;
      r.last   = 1'b1;
      if (model_cnt >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        r.status = STATUS_ACCEPTED;
        span = {{32{it.sleep_ticks[31]}}, it.sleep_ticks};
        due  = now64 + span;
        // clamp a positive overflow past the largest signed deadline
        if (!span[DL_W-1] && due[DL_W-1]) due = {1'b0, {(DL_W-1){1'b1}}};
        pos = 0;
        while (pos < model_cnt && model_dl[pos] <= due) pos++;
        for (i = model_cnt; i > pos; i--) begin
          model_dl[i] = model_dl[i-1];
          model_wt[i] = model_wt[i-1];
        end
        model_dl[pos] = due;
        model_wt[pos] = r.waiter;
        model_cnt++;
      end
      wake_exp_q.push_back(r);
    end else begin
      if (model_ticks != {TICK_W{1'b1}}) model_ticks = model_ticks + 1'b1;
      now64 = {1'b0, model_ticks};
      n = 0;
      while (n < MAX_WAKE_PER_TICK && model_cnt > 0 && model_dl[0] <= now64) begin
        r = '{STATUS_WOKEN, model_wt[0], model_ticks, 1'b0};
        wake_exp_q.push_back(r);
        for (i = 1; i < model_cnt; i++) begin
          model_dl[i-1] = model_dl[i];
          model_wt[i-1] = model_wt[i];
        end
        model_cnt--;
        n++;
      end
      if (n == 0) begin
        r = '{STATUS_NONE_DUE, 8'h00, model_ticks, 1'b1};
        wake_exp_q.push_back(r);
      end else begin
        wake_exp_q[wake_exp_q.size()-1].last = 1'b1;
      end
    end
  endtask

  // Check outgoing transfers, then fold the accepted request into the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (wake_exp_q.size() == 0) begin
          report_mismatch("unexpected result", {56'd0, m_axis_tdata[7:0]}, 64'd0);
        end else begin
          got_want = wake_exp_q.pop_front();
          if (m_axis_tuser !== got_want.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(got_want.status));
          if (m_axis_tdata[7:0] !== got_want.waiter)
            report_mismatch("woken_id", 64'(m_axis_tdata[7:0]), 64'(got_want.waiter));
          if (m_axis_tdata[70:8] !== got_want.now)
            report_mismatch("now_ticks", 64'(m_axis_tdata[70:8]), 64'(got_want.now));
          if (m_axis_tdata[71] !== 1'b0)
            report_mismatch("pad bit", 64'(m_axis_tdata[71]), 64'd0);
          if (m_axis_tlast !== got_want.last)
            report_mismatch("last", 64'(m_axis_tlast), 64'(got_want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_timer_model('{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]});
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      case (phase)
        PH_SEND_IDLE: send_gap = $urandom_range(99) < 47;
        PH_BOTH:      send_gap = $urandom_range(99) < 10;
        default:      send_gap = 1'b0;
      endcase
      if (cmd_q.size() != 0 && !send_gap) begin
        drv_item = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drv_item.waiter_id, drv_item.sleep_ticks};
        s_axis_tuser  <= drv_item.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Hold off the result side for a long stretch once the hold phase starts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (phase == PH_HOLD && hold_cycles < HOLD_LEN) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles + 1;
    end else begin
      case (phase)
        PH_RECV_STALL: recv_ok = $urandom_range(99) >= 47;
        PH_BOTH:       recv_ok = $urandom_range(99) >= 10;
        default:       recv_ok = 1'b1;
      endcase
      m_axis_tready <= recv_ok;
    end
  end

  task automatic push_sleep(input logic [7:0] id, input logic [31:0] span);
    cmd_q.push_back('{CMD_SLEEP, span, id});
  endtask

  task automatic push_tick();
    cmd_q.push_back('{CMD_TICK, $urandom(), 8'($urandom())});
  endtask

  task automatic add_random_items(input int count);
    int          added;
    int          burst;
    int          k;
    int          pick;
    logic [31:0] span;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // several alarms with short spans, then a tick that wakes those already due
        burst = $urandom_range(10, 3);
        for (k = 0; k < burst; k++) push_sleep(8'($urandom()), 32'($urandom_range(2)));
        push_tick();
        added += burst + 1;
      end else if (pick < 60) begin
        push_tick();
        added++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 85)      span = 32'(int'($urandom_range(38)) - 8);
        else if (pick < 93) span = {1'b1, 31'($urandom())};
        else if (pick < 97) span = $urandom();
        else                span = 32'h8000_0000;
        push_sleep(8'($urandom()), span);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || wake_exp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_tick();
    push_sleep(8'h00, 32'd0);
    push_sleep(8'hFF, 32'h8000_0000);
    push_sleep(8'hA5, 32'hFFFF_FFFF);
    push_sleep(8'h5A, 32'd1);
    push_sleep(8'h11, 32'd0);
    push_tick();
    // never due within the run; keeps one slot occupied
    push_sleep(8'h33, 32'h7FFF_FFFF);
    for (k = 0; k < QUEUE_DEPTH - 1; k++)
      push_sleep(8'($urandom()), 32'(-int'($urandom_range(3))));
    push_sleep(8'hC3, 32'd5);
    push_tick();
    wait_drained();

    for (k = 0; k < 5; k++) begin
      @(posedge clk_i);
      phase = phase_e'(k);
      add_random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (wake_exp_q.size() != 0)
      report_mismatch("results never arrived", 64'(wake_exp_q.size()), 64'd0);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
